// ===== rtl/trp_pkg.sv =====
// Shared types, byte codes and result helpers for the Telnet receive parser.
// No dependencies; every other file of the block imports this package.
package trp_pkg;

  // Default depth of the subnegotiation buffer and the longest run emitted for one byte.
  localparam int SUB_DEPTH_DEF = 32;
  localparam int MAX_RUN       = 32;

  // Telnet byte codes.
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_CR   = 8'd13;
  localparam logic [7:0] B_NUL  = 8'd0;
  localparam logic [7:0] B_LF   = 8'd10;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_NOP  = 8'd241;
  localparam logic [7:0] B_DM   = 8'd242;
  localparam logic [7:0] B_GA   = 8'd249;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_DONT = 8'd254;

  // Result kinds.
  localparam logic [2:0] KIND_DATA    = 3'd0;
  localparam logic [2:0] KIND_CMD     = 3'd1;
  localparam logic [2:0] KIND_NEG     = 3'd2;
  localparam logic [2:0] KIND_SUB     = 3'd3;
  localparam logic [2:0] KIND_SUB_NIL = 3'd4;

  typedef enum logic [6:0] {
    PS_NORMAL    = 7'b0000001,
    PS_IAC       = 7'b0000010,
    PS_OPTION    = 7'b0000100,
    PS_CR        = 7'b0001000,
    PS_SB_OPTION = 7'b0010000,
    PS_SB_DATA   = 7'b0100000,
    PS_SB_IAC    = 7'b1000000
  } parse_state_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [2:0] code;
    logic [7:0] opt;
    logic       ovf;
  } trp_res_t;

  // Decision taken for one input byte, handed from the decoder to the control logic.
  typedef struct packed {
    parse_state_e next_state;
    logic [1:0]   verb;
    logic         set_option;
    logic         clear;
    logic         push;
    logic         v0;
    logic         v1;
    logic         run;
    trp_res_t     res0;
    trp_res_t     res1;
  } trp_dec_t;

  function automatic trp_res_t mk_res(logic [2:0] kind, logic [7:0] value,
                                      logic [2:0] code, logic [7:0] opt, logic ovf);
    trp_res_t r;
    r.kind  = kind;
    r.value = value;
    r.code  = code;
    r.opt   = opt;
    r.ovf   = ovf;
    return r;
  endfunction

endpackage

// ===== rtl/trp_decode.sv =====
// Byte decoder of the Telnet receive parser: next parse state, buffer actions
// and up to two immediate results for one byte. Depends on trp_pkg.
module trp_decode (
  input  trp_pkg::parse_state_e state_i,
  input  logic [1:0]            verb_i,
  input  logic [7:0]            option_i,
  input  logic                  sub_ovf_i,
  input  logic                  sub_empty_i,
  input  logic [7:0]            byte_i,
  output trp_pkg::trp_dec_t     dec_o
);
  import trp_pkg::*;

  // Places a result in the first free slot.
  function automatic trp_dec_t emit(trp_dec_t d, trp_res_t r);
    trp_dec_t o;
    o = d;
    if (!o.v0) begin
      o.v0   = 1'b1;
      o.res0 = r;
    end else begin
      o.v1   = 1'b1;
      o.res1 = r;
    end
    return o;
  endfunction

  function automatic trp_dec_t normal_pass(trp_dec_t d, logic [7:0] c);
    trp_dec_t o;
    o = d;
    if (c == B_CR) begin
      o.next_state = PS_CR;
    end else if (c == B_IAC) begin
      o.next_state = PS_IAC;
    end else begin
      o.next_state = PS_NORMAL;
      o = emit(o, mk_res(KIND_DATA, c, 3'd0, 8'd0, 1'b0));
    end
    return o;
  endfunction

  function automatic trp_dec_t iac_pass(trp_dec_t d, logic [7:0] c);
    trp_dec_t o;
    logic [7:0] diff;
    o = d;
    o.next_state = PS_NORMAL;
    diff = c - B_DM;
    if (c == B_SE || c == B_DM) begin
      o.next_state = PS_NORMAL;
    end else if (c >= B_NOP && c <= B_GA) begin
      o = emit(o, mk_res(KIND_CMD, 8'd0, (c == B_NOP) ? 3'd0 : diff[2:0], 8'd0, 1'b0));
    end else if (c == B_SB) begin
      o.next_state = PS_SB_OPTION;
    end else if (c >= B_WILL && c <= B_DONT) begin
      o.verb       = 2'(c - B_WILL);
      o.next_state = PS_OPTION;
    end else begin
      // Escaped 255, or an unknown command whose byte is parsed again as data.
      o = emit(o, mk_res(KIND_DATA, B_IAC, 3'd0, 8'd0, 1'b0));
      if (c != B_IAC) begin
        o = normal_pass(o, c);
      end
    end
    return o;
  endfunction

  always_comb begin
    trp_dec_t d;
    d            = '0;
    d.next_state = PS_NORMAL;
    d.verb       = verb_i;
    unique case (state_i)
      PS_IAC: begin
        d = iac_pass(d, byte_i);
      end
      PS_OPTION: begin
        d = emit(d, mk_res(KIND_NEG, 8'd0, {1'b0, verb_i}, byte_i, 1'b0));
      end
      PS_CR: begin
        if (byte_i == B_NUL) begin
          d = emit(d, mk_res(KIND_DATA, B_CR, 3'd0, 8'd0, 1'b0));
        end else if (byte_i == B_LF) begin
          d = emit(d, mk_res(KIND_DATA, B_LF, 3'd0, 8'd0, 1'b0));
        end else begin
          d = emit(d, mk_res(KIND_DATA, B_CR, 3'd0, 8'd0, 1'b0));
          d = normal_pass(d, byte_i);
        end
      end
      PS_SB_OPTION: begin
        d.set_option = 1'b1;
        d.clear      = 1'b1;
        d.next_state = PS_SB_DATA;
      end
      PS_SB_DATA: begin
        if (byte_i == B_IAC) begin
          d.next_state = PS_SB_IAC;
        end else begin
          d.push       = 1'b1;
          d.next_state = PS_SB_DATA;
        end
      end
      PS_SB_IAC: begin
        if (byte_i == B_IAC) begin
          d.push       = 1'b1;
          d.next_state = PS_SB_DATA;
        end else if (byte_i == B_SE) begin
          if (sub_empty_i) begin
            d = emit(d, mk_res(KIND_SUB_NIL, 8'd0, 3'd0, option_i, sub_ovf_i));
          end else begin
            d.run = 1'b1;
          end
        end else begin
          // Any other command abandons the buffered run.
          d = iac_pass(d, byte_i);
        end
      end
      default: begin
        d = normal_pass(d, byte_i);
      end
    endcase
    dec_o = d;
  end

endmodule

// ===== rtl/trp_sbuf.sv =====
// Subnegotiation byte buffer: one write port and one read port with the read
// data registered. Depends on trp_pkg for the default depth.
module trp_sbuf #(
  parameter int DEPTH = trp_pkg::SUB_DEPTH_DEF,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  import trp_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/telnet_receive_parser_core.sv =====
// Top level of the Telnet receive parser: parse state registers, the output
// register and the run drain. Depends on trp_pkg, trp_decode and trp_sbuf.
//
//   channel   dir  tdata                                         tuser       tlast
//   s_axis    in   [7:0] rx_byte                                 -           -
//   m_axis    out  [7:0] value, [10:8] code, [18:11] option_code [2:0] kind  last
//                  [19] overflowed, [23:20] zero
//
// A byte is taken every cycle while no second result or run is pending and the output
// register is free or being emptied. A byte that yields two results holds the input
// until its second result moves to the output register. IAC SE ending a buffered run
// holds input until the run drains; the buffer is read once a cycle while output is free.
// Reset clears the parse state and counters; the buffer memory needs no clearing pass.
module telnet_receive_parser_core #(
  parameter int SUB_DEPTH = trp_pkg::SUB_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] value, [10:8] code, [18:11] option_code,
                                      // [19] overflowed, [23:20] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);
  import trp_pkg::*;

  localparam int AddrW  = (SUB_DEPTH > 1) ? $clog2(SUB_DEPTH) : 1;
  localparam int CntW   = $clog2(SUB_DEPTH + 1);
  localparam int RunMax = (SUB_DEPTH < MAX_RUN) ? SUB_DEPTH : MAX_RUN;

  typedef enum logic [2:0] {
    CTL_RUN   = 3'b001,
    CTL_PEND  = 3'b010,
    CTL_DRAIN = 3'b100
  } ctl_e;

  ctl_e            ctl_q, ctl_d;
  parse_state_e    state_q, state_d;
  logic [1:0]      verb_q, verb_d;
  logic [7:0]      option_q, option_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            m_valid_q, m_valid_d;
  trp_res_t        out_q, out_d;
  logic            last_q, last_d;
  trp_res_t        pend_q, pend_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] run_len_q, run_len_d;
  logic            rdv_q, rdv_d;
  logic            rdlast_q, rdlast_d;

  trp_dec_t        dec;
  logic            out_free, acc, move, rd_en, mem_we;
  logic [7:0]      rdata;

  trp_decode u_decode (
    .state_i    (state_q),
    .verb_i     (verb_q),
    .option_i   (option_q),
    .sub_ovf_i  (ovf_q),
    .sub_empty_i(count_q == '0),
    .byte_i     (s_axis_tdata),
    .dec_o      (dec)
  );

  // Writes happen only while bytes are accepted and reads only while input is
  // held, so no access to one entry can overlap another.
  trp_sbuf #(
    .DEPTH(SUB_DEPTH),
    .AW   (AddrW)
  ) u_sbuf (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(s_axis_tdata),
    .re_i   (rd_en),
    .raddr_i(rd_idx_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    out_free = !m_valid_q || m_axis_tready;
    acc      = s_axis_tvalid && (ctl_q == CTL_RUN) && out_free;
    move     = (ctl_q == CTL_DRAIN) && rdv_q && out_free;
    rd_en    = (ctl_q == CTL_DRAIN) && (rd_idx_q < run_len_q) && (!rdv_q || move);
    mem_we   = acc && dec.push && (count_q < CntW'(SUB_DEPTH));

    ctl_d     = ctl_q;
    state_d   = state_q;
    verb_d    = verb_q;
    option_d  = option_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    out_d     = out_q;
    last_d    = last_q;
    pend_d    = pend_q;
    rd_idx_d  = rd_idx_q;
    run_len_d = run_len_q;
    rdv_d     = rdv_q;
    rdlast_d  = rdlast_q;

    unique case (ctl_q)
      CTL_RUN: begin
        if (acc) begin
          state_d = dec.next_state;
          verb_d  = dec.verb;
          if (dec.set_option) begin
            option_d = s_axis_tdata;
          end
          if (dec.clear) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end
          if (dec.push) begin
            if (count_q < CntW'(SUB_DEPTH)) begin
              count_d = count_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (dec.v0) begin
            m_valid_d = 1'b1;
            out_d     = dec.res0;
            last_d    = !dec.v1;
          end
          if (dec.v1) begin
            pend_d = dec.res1;
            ctl_d  = CTL_PEND;
          end
          if (dec.run) begin
            ctl_d     = CTL_DRAIN;
            rd_idx_d  = '0;
            rdv_d     = 1'b0;
            run_len_d = (count_q > CntW'(RunMax)) ? CntW'(RunMax) : count_q;
          end
        end
      end
      CTL_PEND: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          out_d     = pend_q;
          last_d    = 1'b1;
          ctl_d     = CTL_RUN;
        end
      end
      CTL_DRAIN: begin
        if (move) begin
          m_valid_d = 1'b1;
          out_d     = mk_res(KIND_SUB, rdata, 3'd0, option_q, ovf_q);
          last_d    = rdlast_q;
          rdv_d     = 1'b0;
          if (rdlast_q) begin
            ctl_d = CTL_RUN;
          end
        end
        if (rd_en) begin
          rd_idx_d = rd_idx_q + 1'b1;
          rdv_d    = 1'b1;
          rdlast_d = (CntW'(rd_idx_q + 1'b1) == run_len_q);
        end
      end
      default: begin
        ctl_d = CTL_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q     <= CTL_RUN;
      state_q   <= PS_NORMAL;
      verb_q    <= '0;
      option_q  <= '0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
      rd_idx_q  <= '0;
      run_len_q <= '0;
      rdv_q     <= 1'b0;
      rdlast_q  <= 1'b0;
    end else begin
      ctl_q     <= ctl_d;
      state_q   <= state_d;
      verb_q    <= verb_d;
      option_q  <= option_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      m_valid_q <= m_valid_d;
      rd_idx_q  <= rd_idx_d;
      run_len_q <= run_len_d;
      rdv_q     <= rdv_d;
      rdlast_q  <= rdlast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    last_q <= last_d;
    pend_q <= pend_d;
  end

  assign s_axis_tready = (ctl_q == CTL_RUN) && out_free;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.ovf, out_q.opt, out_q.code, out_q.value};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = last_q;

endmodule

// ===== rtl/trp_checker.sv =====
// Port-level checks for the Telnet receive parser, bound to the top level.
// Depends on trp_pkg and telnet_receive_parser_core.
module trp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import trp_pkg::*;

  // A result transaction that is stalled keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

  // A stalled output register blocks the input side.
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("byte taken while output is stalled");

  // Only data and subnegotiation bytes carry a value.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_CMD || m_axis_tuser == KIND_NEG
                       || m_axis_tuser == KIND_SUB_NIL)) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("value set on a non-data result");

  // The overflow flag belongs to subnegotiation results alone.
  a_ovf_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[19]) |->
      (m_axis_tuser == KIND_SUB || m_axis_tuser == KIND_SUB_NIL))
    else $error("overflow flag on a non-subnegotiation result");

  // Every result carries a known kind and zero padding above the flag.
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= KIND_SUB_NIL) && (m_axis_tdata[23:20] == 4'd0))
    else $error("result kind or padding out of range");

endmodule

bind telnet_receive_parser_core trp_checker u_trp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
